### hdl/bero_pkg.sv
package bero_pkg;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned WIDTH_RST   = 640;
  localparam int unsigned HEIGHT_RST  = 480;
  localparam int unsigned OFIFO_DEPTH = 3;
  localparam int unsigned OFIFO_CNT_W = 2;
  localparam int unsigned OFIFO_PTR_W = 2;

  localparam logic [PIX_W-1:0] WHITE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'd0,
    REG_IMAGE_HEIGHT = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic             last;
    logic             skip_top;
    logic             skip_bot;
    logic             skip_left;
    logic             skip_right;
    logic [PIX_W-1:0] pix;
  } issue_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } result_t;

endpackage

### hdl/bero_ram.sv
module bero_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bero_ctrl.sv
module bero_ctrl #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_tvalid_i,
  output logic                                 s_tready_o,
  input  logic [bero_pkg::PIX_W-1:0]           s_tdata_i,
  input  logic                                 s_tuser_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bero_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bero_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic [bero_pkg::OFIFO_CNT_W-1:0]     fifo_cnt_i,
  input  logic                                 s1_emit_i,
  output bero_pkg::issue_t                     iss_o,
  output logic [$clog2(MAX_WIDTH)-1:0]         iss_col_o,
  output logic                                 clr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]         clr_addr_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned OCW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned PW  = WW + HW;
  localparam int unsigned EWW = (bero_pkg::CFG_W > WW) ? bero_pkg::CFG_W : WW;
  localparam int unsigned EHW = (bero_pkg::CFG_W > HW) ? bero_pkg::CFG_W : HW;
  localparam int unsigned W_RST =
    (bero_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : bero_pkg::WIDTH_RST;
  localparam int unsigned H_RST =
    (bero_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : bero_pkg::HEIGHT_RST;
  localparam int unsigned FCW = bero_pkg::OFIFO_CNT_W + 1;

  logic [WW-1:0]  w_q, w_d;
  logic [HW-1:0]  h_q, h_d;
  logic [CW-1:0]  col_q, col_d;
  logic [RW-1:0]  row_q, row_d;
  logic [OCW-1:0] oc_q, oc_d;
  logic           clearing_q, clearing_d;
  logic [CW-1:0]  clr_q, clr_d;

  logic [EWW-1:0] wv_ext;
  logic [EHW-1:0] hv_ext;
  logic [WW-1:0]  w_cfg;
  logic [HW-1:0]  h_cfg;

  logic           room, accept, frame_in, take;
  logic           c_zero, c_one, c_ge_w, w_is1, emit, last;
  logic [RW-1:0]  h_row;
  logic [PW-1:0]  frame_size;
  logic [OCW:0]   oc_inc;
  logic [CW:0]    c_inc;

  assign cfg_ready_o = 1'b1;

  assign wv_ext = EWW'(cfg_data_i);
  assign hv_ext = EHW'(cfg_data_i);
  assign w_cfg  = (wv_ext == '0) ? WW'(1) :
                  (wv_ext > EWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(wv_ext);
  assign h_cfg  = (hv_ext == '0) ? HW'(1) :
                  (hv_ext > EHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(hv_ext);

  always_comb begin
    w_d = w_q;
    h_d = h_q;
    if (cfg_valid_i) begin
      unique case (bero_pkg::cfg_reg_e'(cfg_index_i))
        bero_pkg::REG_IMAGE_WIDTH:  w_d = w_cfg;
        bero_pkg::REG_IMAGE_HEIGHT: h_d = h_cfg;
        default: ;
      endcase
    end
  end

  assign room       = (FCW'(fifo_cnt_i) + FCW'(s1_emit_i)) <= FCW'(2);
  assign s_tready_o = !clearing_q && room;
  assign accept     = s_tvalid_i && s_tready_o;

  assign h_row      = RW'(h_q);
  assign frame_in   = row_q < h_row;
  assign take       = accept && !(s_tuser_i && frame_in);

  assign c_zero     = col_q == '0;
  assign c_one      = col_q == CW'(1);
  assign c_ge_w     = (CW + 1)'(col_q) >= (CW + 1)'(w_q);
  assign w_is1      = w_q == WW'(1);
  assign emit       = (row_q >= RW'(2)) || ((row_q == RW'(1)) && !c_zero);
  assign frame_size = PW'(w_q) * PW'(h_q);
  assign oc_inc     = (OCW + 1)'(oc_q) + (OCW + 1)'(1);
  assign last       = emit && (PW'(oc_inc) == frame_size);
  assign c_inc      = (CW + 1)'(col_q) + (CW + 1)'(1);

  always_comb begin
    iss_o.valid      = take;
    iss_o.emit       = emit;
    iss_o.last       = last;
    iss_o.skip_top   = c_zero ? (row_q == RW'(2)) : (row_q == RW'(1));
    iss_o.skip_bot   = c_zero ? (row_q > h_row) : (row_q >= h_row);
    iss_o.skip_left  = (c_zero && w_is1) || c_one;
    iss_o.skip_right = c_zero || c_ge_w;
    iss_o.pix        = frame_in ? s_tdata_i : '0;
  end
  assign iss_col_o = col_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    oc_d  = oc_q;
    if (take) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
        oc_d  = '0;
      end else begin
        if (emit) begin
          oc_d = oc_inc[OCW-1:0];
        end
        if (c_inc >= (CW + 1)'(w_q)) begin
          col_d = '0;
          if (row_q != '1) begin
            row_d = row_q + RW'(1);
          end
        end else begin
          col_d = c_inc[CW-1:0];
        end
      end
    end
  end

  always_comb begin
    clr_d      = clr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      if (clr_q == CW'(MAX_WIDTH - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_d = clr_q + CW'(1);
      end
    end
  end

  assign clr_en_o   = clearing_q;
  assign clr_addr_o = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q        <= WW'(W_RST);
      h_q        <= HW'(H_RST);
      col_q      <= '0;
      row_q      <= '0;
      oc_q       <= '0;
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else begin
      w_q        <= w_d;
      h_q        <= h_d;
      col_q      <= col_d;
      row_q      <= row_d;
      oc_q       <= oc_d;
      clearing_q <= clearing_d;
      clr_q      <= clr_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && last |=> col_q == '0 && row_q == '0 && oc_q == '0)
    else $error("position counters not cleared after frame end");
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CW + 1)'(col_q) < (CW + 1)'(MAX_WIDTH))
    else $error("column beyond line store depth");
`endif

endmodule

### hdl/bero_win.sv
module bero_win #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bero_pkg::issue_t                   iss_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]       iss_col_i,
  input  logic [2*bero_pkg::PIX_W-1:0]       ram_rdata_i,
  output logic                               wr_en_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       wr_addr_o,
  output logic [2*bero_pkg::PIX_W-1:0]       wr_data_o,
  output logic                               res_valid_o,
  output bero_pkg::result_t                  res_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = bero_pkg::PIX_W;

  bero_pkg::issue_t s1_q;
  logic [CW-1:0]    s1_col_q;
  logic             wr_valid_q;
  logic [CW-1:0]    wr_col_q;
  logic [2*PW-1:0]  wr_data_q;
  logic [PW-1:0]    win_q [3][3];
  logic [PW-1:0]    win_d [3][3];

  logic             fwd;
  logic [2*PW-1:0]  line_pair;
  logic [PW-1:0]    up, mid, center;
  logic             black_near;
  logic [2:0]       row_use, col_use;

  assign fwd       = s1_q.valid && wr_valid_q && (wr_col_q == s1_col_q);
  assign line_pair = fwd ? wr_data_q : ram_rdata_i;
  assign up        = line_pair[2*PW-1:PW];
  assign mid       = line_pair[PW-1:0];

  assign wr_en_o   = s1_q.valid;
  assign wr_addr_o = s1_col_q;
  assign wr_data_o = {mid, s1_q.pix};

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = up;
    win_d[1][2] = mid;
    win_d[2][2] = s1_q.pix;
  end

  assign row_use = {!s1_q.skip_bot, 1'b1, !s1_q.skip_top};
  assign col_use = {!s1_q.skip_right, 1'b1, !s1_q.skip_left};
  assign center  = win_d[1][1];

  always_comb begin
    black_near = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (row_use[r] && col_use[k] && (win_d[r][k] == '0)) begin
          black_near = 1'b1;
        end
      end
    end
  end

  assign res_valid_o = s1_q.valid && s1_q.emit;
  assign res_o.last  = s1_q.last;
  assign res_o.pix   = ((center == bero_pkg::WHITE) && black_near) ? '0 : center;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q       <= '0;
      s1_col_q   <= '0;
      wr_valid_q <= 1'b0;
      wr_col_q   <= '0;
      wr_data_q  <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else begin
      s1_q       <= iss_i;
      s1_col_q   <= iss_col_i;
      wr_valid_q <= s1_q.valid;
      wr_col_q   <= s1_col_q;
      wr_data_q  <= wr_data_o;
      if (s1_q.valid) begin
        win_q <= win_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.valid && s1_q.last |-> s1_q.emit)
    else $error("frame end flagged on an item without output");
`endif

endmodule

### hdl/bero_ofifo.sv
module bero_ofifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  bero_pkg::result_t                 push_data_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output bero_pkg::result_t                 m_data_o,
  output logic [bero_pkg::OFIFO_CNT_W-1:0]  cnt_o
);

  localparam int unsigned DEPTH = bero_pkg::OFIFO_DEPTH;
  localparam int unsigned PTW   = bero_pkg::OFIFO_PTR_W;
  localparam int unsigned CNW   = bero_pkg::OFIFO_CNT_W;

  bero_pkg::result_t mem_q [DEPTH];
  logic [PTW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNW-1:0]    cnt_q, cnt_d;
  logic              pop;

  assign pop        = m_tvalid_o && m_tready_i;
  assign m_tvalid_o = cnt_q != '0;
  assign m_data_o   = mem_q[rd_q];
  assign cnt_o      = cnt_q;

  assign wr_d  = !push_i ? wr_q : (wr_q == PTW'(DEPTH - 1)) ? '0 : wr_q + PTW'(1);
  assign rd_d  = !pop ? rd_q : (rd_q == PTW'(DEPTH - 1)) ? '0 : rd_q + PTW'(1);
  assign cnt_d = cnt_q + CNW'(push_i) - CNW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != CNW'(DEPTH))
    else $error("result queue overflow");
`endif

endmodule

### hdl/binary_erosion_3x3_stream_core.sv
// Channel   Dir  Handshake               Payload
// s_*       in   s_tvalid_i/s_tready_o   tdata: pixel_in[7:0]; tuser: cmd
// m_*       out  m_tvalid_o/m_tready_i   tdata: pixel_out[7:0]; tlast: frame_last
// cfg_*     in   cfg_valid_i/cfg_ready_o index 0 image_width, 1 image_height
//
// One item per clock unless input stalls: the column counter feeds the
// line-store read port, the window stage writes back in the next cycle and
// forwards on a same-column hit. Each result leaves via a 3-entry queue.
// After reset a clearing pass zeroes all MAX_WIDTH line-store entries;
// s_tready_o stays low meanwhile. Apart from that, input stalls only when the
// queue plus the window stage could not absorb another result.
module binary_erosion_3x3_stream_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [bero_pkg::PIX_W-1:0]     s_tdata_i,   // [7:0] pixel_in
  input  logic                           s_tuser_i,   // [0] cmd
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [bero_pkg::PIX_W-1:0]     m_tdata_o,   // [7:0] pixel_out
  output logic                           m_tlast_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bero_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bero_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned LW = 2 * bero_pkg::PIX_W;

  bero_pkg::issue_t  iss;
  bero_pkg::result_t res, head;
  logic [CW-1:0]     iss_col, clr_addr, win_addr, ram_waddr;
  logic              clr_en, win_wr_en, ram_we, res_valid;
  logic [LW-1:0]     ram_rdata, win_wdata, ram_wdata;
  logic [bero_pkg::OFIFO_CNT_W-1:0] fifo_cnt;

  bero_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_cnt_i  (fifo_cnt),
    .s1_emit_i   (res_valid),
    .iss_o       (iss),
    .iss_col_o   (iss_col),
    .clr_en_o    (clr_en),
    .clr_addr_o  (clr_addr)
  );

  assign ram_we    = clr_en || win_wr_en;
  assign ram_waddr = clr_en ? clr_addr : win_addr;
  assign ram_wdata = clr_en ? '0 : win_wdata;

  bero_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (iss.valid),
    .raddr_i (iss_col),
    .rdata_o (ram_rdata)
  );

  bero_win #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_i       (iss),
    .iss_col_i   (iss_col),
    .ram_rdata_i (ram_rdata),
    .wr_en_o     (win_wr_en),
    .wr_addr_o   (win_addr),
    .wr_data_o   (win_wdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bero_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_data_o    (head),
    .cnt_o       (fifo_cnt)
  );

  assign m_tdata_o = head.pix;
  assign m_tlast_o = head.last;

`ifndef NO_ASSERTIONS
  a_clear_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(clr_en && (win_wr_en || iss.valid)))
    else $error("line store access during clearing pass");
`endif

endmodule
